FILE: sv/asc_pkg.sv
// Shared constants and codes for the analog stick conditioner.
// No dependencies; analog_stick_conditioner imports this package.
`timescale 1ns / 1ps
`default_nettype none

package asc_pkg;

    // Output axis width
    localparam int OUT_W = 16;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEADZONE     = 3'd0,
        REG_AUTO_CAL     = 3'd1,
        REG_FORCE_CIRCLE = 3'd2,
        REG_INVERT0      = 3'd3,
        REG_INVERT1      = 3'd4,
        REG_ROUTE0       = 3'd5,
        REG_ROUTE1       = 3'd6
    } t_cfg_reg;

    // Input commands
    localparam logic CMD_CALIBRATE = 1'b0;
    localparam logic CMD_SAMPLE    = 1'b1;

    // Destination codes
    typedef enum logic [1:0] {
        ROUTE_NONE  = 2'd0,
        ROUTE_LEFT  = 2'd1,
        ROUTE_RIGHT = 2'd2
    } t_route;

    // Inversion bits within an invert register
    localparam int INV_X = 0;
    localparam int INV_Y = 1;

    // Deadzone setting: width, clamp and scale (radius in 1/200 of full scale)
    localparam int DZ_W     = 7;
    localparam int DZ_LIMIT = 100;
    localparam int DZ_SCALE = 200;

endpackage

`default_nettype wire

FILE: sv/analog_stick_conditioner.sv
// Top level of the analog stick conditioner: centers, remap, deadzone, circle.
// Depends on asc_pkg, asc_div, asc_sqrt and asc_delay.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-----------------------------------------
//  input    | i_in_valid / o_in_stall  | command, stick, raw_x, raw_y, x/y_present
//  output   | o_out_valid / i_out_stall| from_stick, out_x, out_y, destination
//  config   | i_cfg_we                 | i_cfg_idx, i_cfg_data
//
// One transaction enters per cycle while o_in_stall is low; a sample reaches
// the output register through stages A to I and the units between them.
// The depth comes from the bit-per-stage dividers and square root in series.
// Calibrate transactions update the center store at acceptance and give no result.
// Synchronous reset clears valid bits and config registers; centers go to midscale.
// A stalled result freezes the pipeline, except that a bubble in the last stage
// lets the pipe keep advancing and taking input behind the waiting result.
`timescale 1ns / 1ps
`default_nettype none

module analog_stick_conditioner
    import asc_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int FRAC_BITS   = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_command,
    input  logic                   i_stick,
    input  logic [SAMPLE_BITS-1:0] i_raw_x,
    input  logic [SAMPLE_BITS-1:0] i_raw_y,
    input  logic                   i_x_present,
    input  logic                   i_y_present,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_from_stick,
    output logic [OUT_W-1:0]       o_out_x,
    output logic [OUT_W-1:0]       o_out_y,
    output logic [1:0]             o_destination,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int SB   = SAMPLE_BITS;
    localparam int F    = FRAC_BITS;
    localparam int NUMW = 2 * SB;
    localparam int PW   = F + 4;
    localparam int QS   = F + 2;
    localparam int NK   = F / SB + 2;
    localparam int NT   = F + NK * SB;

    localparam logic [SB-1:0] ADC_MAX   = SB'((longint'(1) << SB) - 1);
    localparam logic [SB-1:0] HALF_CODE = ADC_MAX >> 1;
    localparam logic [F:0]    ONE       = (F+1)'(longint'(1) << F);
    localparam logic [F:0]    HALF      = (F+1)'(longint'(1) << (F - 1));

    typedef struct packed {
        logic [NUMW-1:0] num;
        logic [SB-1:0]   den;
        logic            add;
    } t_map;

    typedef struct packed {
        logic valid;
        logic st;
        logic xp;
        logic yp;
        logic addx;
        logic addy;
    } t_side1;

    typedef struct packed {
        logic valid;
        logic st;
        logic xp;
        logic yp;
    } t_side2;

    typedef struct packed {
        logic         valid;
        logic         st;
        logic         both;
        logic         negx;
        logic         negy;
        logic [F-1:0] adx;
        logic [F-1:0] ady;
        logic [F:0]   px;
        logic [F:0]   py;
    } t_side3;

    typedef struct packed {
        logic         valid;
        logic         st;
        logic         both;
        logic         negx;
        logic         negy;
        logic [F-1:0] adx;
        logic [F-1:0] ady;
        logic [F:0]   px;
        logic [F:0]   py;
        logic [F-1:0] m;
        logic         small_m;
        logic         far;
    } t_side4;

    typedef struct packed {
        logic          valid;
        logic          st;
        logic          both;
        logic          negx;
        logic          negy;
        logic [F:0]    px;
        logic [F:0]    py;
        logic          small_m;
        logic          far;
        logic [QS-1:0] ocx;
        logic [QS-1:0] ocy;
    } t_side5;

    // Configuration registers
    logic [DZ_W-1:0] r_deadzone;
    logic            r_auto_cal;
    logic            r_force_circle;
    logic [1:0]      r_invert [2];
    logic [1:0]      r_route  [2];

    // Center store, one X and one Y entry per stick
    logic [SB-1:0] r_center_x [2];
    logic [SB-1:0] r_center_y [2];

    // Deadzone radius and denominator, looked up from the setting
    logic [F-1:0] w_dz_tab  [1 << DZ_W];
    logic [F:0]   w_den_tab [1 << DZ_W];
    logic [F-1:0] r_dz;
    logic [F:0]   r_den;
    logic         r_dz_on;

    logic w_adv;
    logic w_acc;

    // Global advance: hold only when the waiting result would be overwritten
    logic r_i_valid;
    logic r_out_valid;
    assign w_adv      = !(r_out_valid && i_out_stall && r_i_valid);
    assign o_in_stall = !w_adv;
    assign w_acc      = i_in_valid && w_adv;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadzone     <= '0;
            r_auto_cal     <= 1'b0;
            r_force_circle <= 1'b0;
            r_invert[0]    <= '0;
            r_invert[1]    <= '0;
            r_route[0]     <= '0;
            r_route[1]     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DEADZONE:     r_deadzone     <= i_cfg_data[DZ_W-1:0];
                REG_AUTO_CAL:     r_auto_cal     <= i_cfg_data[0];
                REG_FORCE_CIRCLE: r_force_circle <= i_cfg_data[0];
                REG_INVERT0:      r_invert[0]    <= i_cfg_data[1:0];
                REG_INVERT1:      r_invert[1]    <= i_cfg_data[1:0];
                REG_ROUTE0:       r_route[0]     <= i_cfg_data[1:0];
                REG_ROUTE1:       r_route[1]     <= i_cfg_data[1:0];
                default:          ;
            endcase
        end
    end

    // Build the deadzone table at elaboration; settings above the limit clamp
    for (genvar g = 0; g < (1 << DZ_W); g++) begin : g_dz
        localparam longint SETV = (g > DZ_LIMIT) ? DZ_LIMIT : g;
        localparam longint DZV  = (SETV << F) / DZ_SCALE;
        localparam longint DENV = (longint'(1) << F) - DZV - (DZV * 3) / 5;
        assign w_dz_tab[g]  = F'(DZV);
        assign w_den_tab[g] = (F+1)'(DENV);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dz    <= '0;
            r_den   <= ONE;
            r_dz_on <= 1'b0;
        end else begin
            r_dz    <= w_dz_tab[r_deadzone];
            r_den   <= w_den_tab[r_deadzone];
            r_dz_on <= r_deadzone != '0;
        end
    end

    // Store centers of present axes on a calibrate transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 2; k++) begin
                r_center_x[k] <= HALF_CODE;
                r_center_y[k] <= HALF_CODE;
            end
        end else if (w_acc && i_command == CMD_CALIBRATE) begin
            if (i_x_present) r_center_x[i_stick] <= i_raw_x;
            if (i_y_present) r_center_y[i_stick] <= i_raw_y;
        end
    end

    // ---------------- Stage A: capture sample and its centers ----------------
    logic          r_a_valid;
    logic          r_a_st;
    logic          r_a_xp;
    logic          r_a_yp;
    logic [SB-1:0] r_a_rx;
    logic [SB-1:0] r_a_ry;
    logic [SB-1:0] r_a_cx;
    logic [SB-1:0] r_a_cy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_adv) begin
            r_a_valid <= w_acc && i_command == CMD_SAMPLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_st <= i_stick;
            r_a_xp <= i_x_present;
            r_a_yp <= i_y_present;
            r_a_rx <= i_raw_x;
            r_a_ry <= i_raw_y;
            r_a_cx <= r_center_x[i_stick];
            r_a_cy <= r_center_y[i_stick];
        end
    end

    // Pick the remap segment: above center, at center, below center or raw
    function automatic t_map map_axis(input logic [SB-1:0] h, input logic [SB-1:0] c,
                                      input logic cal);
        t_map res;
        res.num = '0;
        res.den = SB'(1);
        res.add = 1'b0;
        if (!cal) begin
            res.num = NUMW'(h);
        end else if (h > c) begin
            res.num = NUMW'(h - c) << (SB - 1);
            res.den = ADC_MAX - c;
            res.add = 1'b1;
        end else if (h == c) begin
            res.add = 1'b1;
        end else begin
            res.num = (NUMW'(h) << (SB - 1)) - NUMW'(h);
            res.den = c;
        end
        return res;
    endfunction

    t_map w_map_x;
    t_map w_map_y;
    assign w_map_x = map_axis(r_a_rx, r_a_cx, r_auto_cal);
    assign w_map_y = map_axis(r_a_ry, r_a_cy, r_auto_cal);

    // ---------------- Remap dividers ----------------
    logic [SB-1:0] w_q1_x;
    logic [SB-1:0] w_q1_y;
    t_side1        w_s1_in;
    t_side1        w_s1;

    asc_div #(.NW(NUMW), .DW(SB), .QW(SB)) u_map_x (
        .i_clk(i_clk), .i_en(w_adv), .i_num(w_map_x.num), .i_den(w_map_x.den),
        .o_quo(w_q1_x)
    );
    asc_div #(.NW(NUMW), .DW(SB), .QW(SB)) u_map_y (
        .i_clk(i_clk), .i_en(w_adv), .i_num(w_map_y.num), .i_den(w_map_y.den),
        .o_quo(w_q1_y)
    );

    assign w_s1_in = '{valid: r_a_valid, st: r_a_st, xp: r_a_xp, yp: r_a_yp,
                       addx: w_map_x.add, addy: w_map_y.add};

    asc_delay #(.W($bits(t_side1)), .DEPTH(SB)) u_dly1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv), .i_d(w_s1_in), .o_q(w_s1)
    );

    // ---------------- Stage B: normalize to fixed point ----------------
    // Divide by ADC_MAX as a sum of shifted copies of the code; full scale is exact
    function automatic logic [F:0] normalize(input logic [SB-1:0] c);
        logic [NT-1:0] t;
        t = '0;
        for (int k = 0; k < NK; k++) t = t + (NT'(c) << (F + k * SB));
        if (c == ADC_MAX) return ONE;
        return (F+1)'(t >> (NK * SB));
    endfunction

    logic [SB-1:0] w_code_x;
    logic [SB-1:0] w_code_y;
    t_side2        r_b_side;
    logic [F:0]    r_b_qx;
    logic [F:0]    r_b_qy;

    assign w_code_x = w_q1_x + (w_s1.addx ? HALF_CODE : '0);
    assign w_code_y = w_q1_y + (w_s1.addy ? HALF_CODE : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_side <= '0;
        end else if (w_adv) begin
            r_b_side <= '{valid: w_s1.valid, st: w_s1.st, xp: w_s1.xp, yp: w_s1.yp};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b_qx <= normalize(w_code_x);
            r_b_qy <= normalize(w_code_y);
        end
    end

    // ---------------- Stage C: invert and center absent axes ----------------
    logic [1:0] w_inv;
    logic       r_c_valid;
    logic       r_c_st;
    logic       r_c_both;
    logic [F:0] r_c_px;
    logic [F:0] r_c_py;

    assign w_inv = r_b_side.st ? r_invert[1] : r_invert[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_adv) begin
            r_c_valid <= r_b_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c_st   <= r_b_side.st;
            r_c_both <= r_b_side.xp && r_b_side.yp;
            r_c_px   <= !r_b_side.xp ? HALF : (w_inv[INV_X] ? ONE - r_b_qx : r_b_qx);
            r_c_py   <= !r_b_side.yp ? HALF : (w_inv[INV_Y] ? ONE - r_b_qy : r_b_qy);
        end
    end

    // ---------------- Stage D: offsets from center ----------------
    logic         r_d_valid;
    logic         r_d_st;
    logic         r_d_both;
    logic         r_d_negx;
    logic         r_d_negy;
    logic [F-1:0] r_d_adx;
    logic [F-1:0] r_d_ady;
    logic [F:0]   r_d_px;
    logic [F:0]   r_d_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (w_adv) begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d_st   <= r_c_st;
            r_d_both <= r_c_both;
            r_d_negx <= r_c_px < HALF;
            r_d_negy <= r_c_py < HALF;
            r_d_adx  <= (r_c_px < HALF) ? F'(HALF - r_c_px) : F'(r_c_px - HALF);
            r_d_ady  <= (r_c_py < HALF) ? F'(HALF - r_c_py) : F'(r_c_py - HALF);
            r_d_px   <= r_c_px;
            r_d_py   <= r_c_py;
        end
    end

    // ---------------- Stage E: squares ----------------
    logic           r_e_valid;
    t_side3         r_e_side;
    logic [2*F-1:0] r_e_sqx;
    logic [2*F-1:0] r_e_sqy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (w_adv) begin
            r_e_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_e_side <= '{valid: 1'b0, st: r_d_st, both: r_d_both, negx: r_d_negx,
                          negy: r_d_negy, adx: r_d_adx, ady: r_d_ady,
                          px: r_d_px, py: r_d_py};
            r_e_sqx  <= (2*F)'(r_d_adx) * (2*F)'(r_d_adx);
            r_e_sqy  <= (2*F)'(r_d_ady) * (2*F)'(r_d_ady);
        end
    end

    // ---------------- Stage F: sum of squares ----------------
    logic           r_f_valid;
    t_side3         r_f_side;
    logic [2*F-1:0] r_f_sum;
    t_side3         w_s3_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (w_adv) begin
            r_f_valid <= r_e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f_side <= r_e_side;
            r_f_sum  <= r_e_sqx + r_e_sqy;
        end
    end

    always_comb begin
        w_s3_in       = r_f_side;
        w_s3_in.valid = r_f_valid;
    end

    // ---------------- Magnitude ----------------
    logic [F-1:0] w_m;
    t_side3       w_s3;

    asc_sqrt #(.RW(F)) u_mag (
        .i_clk(i_clk), .i_en(w_adv), .i_val(r_f_sum), .o_root(w_m)
    );

    asc_delay #(.W($bits(t_side3)), .DEPTH(F)) u_dly3 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv), .i_d(w_s3_in), .o_q(w_s3)
    );

    // ---------------- Deadzone scale and circle offsets ----------------
    logic          w_small;
    logic [F-1:0]  w_m_den;
    logic [QS-1:0] w_s;
    logic [QS-1:0] w_ocx;
    logic [QS-1:0] w_ocy;
    t_side4        w_s4_in;
    t_side4        w_s4;

    assign w_small = (w_m < r_dz) || (w_m == '0);
    assign w_m_den = (w_m == '0) ? F'(1) : w_m;

    asc_div #(.NW(2 * F), .DW(F + 1), .QW(QS)) u_scale (
        .i_clk(i_clk), .i_en(w_adv),
        .i_num(w_small ? '0 : ((2*F)'(w_m - r_dz) << F)), .i_den(r_den),
        .o_quo(w_s)
    );
    asc_div #(.NW(2 * F), .DW(F), .QW(QS)) u_circ_x (
        .i_clk(i_clk), .i_en(w_adv), .i_num((2*F)'(w_s3.adx) << (F - 1)), .i_den(w_m_den),
        .o_quo(w_ocx)
    );
    asc_div #(.NW(2 * F), .DW(F), .QW(QS)) u_circ_y (
        .i_clk(i_clk), .i_en(w_adv), .i_num((2*F)'(w_s3.ady) << (F - 1)), .i_den(w_m_den),
        .o_quo(w_ocy)
    );

    assign w_s4_in = '{valid: w_s3.valid, st: w_s3.st, both: w_s3.both, negx: w_s3.negx,
                       negy: w_s3.negy, adx: w_s3.adx, ady: w_s3.ady, px: w_s3.px,
                       py: w_s3.py, m: w_m, small_m: w_small, far: F'(HALF) < w_m};

    asc_delay #(.W($bits(t_side4)), .DEPTH(QS)) u_dly4 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv), .i_d(w_s4_in), .o_q(w_s4)
    );

    // ---------------- Stage H: scaled offset products ----------------
    t_side5          r_h_side;
    logic [F-1:0]    r_h_m;
    logic [F+QS-1:0] r_h_prodx;
    logic [F+QS-1:0] r_h_prody;
    logic            r_h_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_valid <= 1'b0;
        end else if (w_adv) begin
            r_h_valid <= w_s4.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_h_side  <= '{valid: 1'b0, st: w_s4.st, both: w_s4.both, negx: w_s4.negx,
                           negy: w_s4.negy, px: w_s4.px, py: w_s4.py,
                           small_m: w_s4.small_m, far: w_s4.far, ocx: w_ocx, ocy: w_ocy};
            r_h_m     <= (w_s4.m == '0) ? F'(1) : w_s4.m;
            r_h_prodx <= (F+QS)'(w_s4.adx) * (F+QS)'(w_s);
            r_h_prody <= (F+QS)'(w_s4.ady) * (F+QS)'(w_s);
        end
    end

    // ---------------- Deadzone offsets ----------------
    logic [QS-1:0] w_odx;
    logic [QS-1:0] w_ody;
    t_side5        w_s5_in;
    t_side5        w_s5;

    asc_div #(.NW(F + QS), .DW(F), .QW(QS)) u_off_x (
        .i_clk(i_clk), .i_en(w_adv), .i_num(r_h_prodx), .i_den(r_h_m), .o_quo(w_odx)
    );
    asc_div #(.NW(F + QS), .DW(F), .QW(QS)) u_off_y (
        .i_clk(i_clk), .i_en(w_adv), .i_num(r_h_prody), .i_den(r_h_m), .o_quo(w_ody)
    );

    always_comb begin
        w_s5_in       = r_h_side;
        w_s5_in.valid = r_h_valid;
    end

    asc_delay #(.W($bits(t_side5)), .DEPTH(QS)) u_dly5 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv), .i_d(w_s5_in), .o_q(w_s5)
    );

    // ---------------- Stage I: select final position ----------------
    function automatic logic [PW-1:0] place(input logic neg, input logic [QS-1:0] o);
        return neg ? PW'(HALF) - PW'(o) : PW'(HALF) + PW'(o);
    endfunction

    logic [PW-1:0] w_fpx;
    logic [PW-1:0] w_fpy;
    logic          r_i_st;
    logic [PW-1:0] r_i_fpx;
    logic [PW-1:0] r_i_fpy;

    always_comb begin
        w_fpx = PW'(w_s5.px);
        w_fpy = PW'(w_s5.py);
        if (w_s5.both) begin
            if (r_dz_on) begin
                w_fpx = w_s5.small_m ? PW'(HALF) : place(w_s5.negx, w_odx);
                w_fpy = w_s5.small_m ? PW'(HALF) : place(w_s5.negy, w_ody);
            end
            if (r_force_circle && w_s5.far) begin
                w_fpx = place(w_s5.negx, w_s5.ocx);
                w_fpy = place(w_s5.negy, w_s5.ocy);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_valid <= 1'b0;
        end else if (w_adv) begin
            r_i_valid <= w_s5.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_i_st  <= w_s5.st;
            r_i_fpx <= w_fpx;
            r_i_fpy <= w_fpy;
        end
    end

    // ---------------- Stage J: scale to 16 bits and route ----------------
    function automatic logic [OUT_W-1:0] to16(input logic [PW-1:0] p);
        logic [F+OUT_W-1:0] sc;
        sc = (F+OUT_W)'(p[F-1:0]);
        sc = (sc << OUT_W) - sc;
        if (p[PW-1] || p == '0) return '0;
        else if (p >= PW'(ONE)) return '1;
        else return sc[F+OUT_W-1:F];
    endfunction

    logic [1:0] w_route;
    logic [1:0] w_dest;

    assign w_route = r_i_st ? r_route[1] : r_route[0];

    always_comb begin
        unique case (w_route)
            ROUTE_LEFT:  w_dest = ROUTE_LEFT;
            ROUTE_RIGHT: w_dest = ROUTE_RIGHT;
            default:     w_dest = ROUTE_NONE;
        endcase
    end

    // Load the output register unless a result still waits on a stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            r_out_valid <= r_i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_out_stall) begin
            o_from_stick  <= r_i_st;
            o_out_x       <= to16(r_i_fpx);
            o_out_y       <= to16(r_i_fpy);
            o_destination <= w_dest;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

FILE: sv/asc_div.sv
// Pipelined restoring divider: one quotient bit per register stage.
// Uses no package items; instantiated by analog_stick_conditioner.
`timescale 1ns / 1ps
`default_nettype none

module asc_div #(
    parameter int NW = 24,
    parameter int DW = 12,
    parameter int QW = 12
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);

    localparam int WW = (NW > DW + QW) ? NW : DW + QW;

    logic [NW-1:0] w_rem_q [QW];
    logic [DW-1:0] w_den_q [QW];
    logic [QW-1:0] w_quo_q [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int B = QW - 1 - k;
        logic [NW-1:0] w_rem;
        logic [DW-1:0] w_den;
        logic [QW-1:0] w_quo;
        logic [WW-1:0] w_sh;
        logic          w_ge;
        logic [NW-1:0] r_rem;
        logic [DW-1:0] r_den;
        logic [QW-1:0] r_quo;

        // Take the operands from the port or from the stage before
        if (k == 0) begin : g_first
            assign w_rem = i_num;
            assign w_den = i_den;
            assign w_quo = '0;
        end else begin : g_next
            assign w_rem = w_rem_q[k-1];
            assign w_den = w_den_q[k-1];
            assign w_quo = w_quo_q[k-1];
        end

        // Try the shifted divisor against the partial remainder
        assign w_sh = WW'(w_den) << B;
        assign w_ge = WW'(w_rem) >= w_sh;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= w_ge ? NW'(WW'(w_rem) - w_sh) : w_rem;
                r_den <= w_den;
                r_quo <= w_quo | (QW'(w_ge) << B);
            end
        end

        assign w_rem_q[k] = r_rem;
        assign w_den_q[k] = r_den;
        assign w_quo_q[k] = r_quo;
    end

    assign o_quo = w_quo_q[QW-1];

endmodule

`default_nettype wire

FILE: sv/asc_sqrt.sv
// Pipelined integer square root (floor), one root bit per register stage.
// Uses no package items; instantiated by analog_stick_conditioner.
`timescale 1ns / 1ps
`default_nettype none

module asc_sqrt #(
    parameter int RW = 16
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [2*RW-1:0] i_val,
    output logic [RW-1:0]   o_root
);

    localparam int IW = 2 * RW;

    logic [IW-1:0] w_rem_q  [RW];
    logic [RW-1:0] w_root_q [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        localparam int J = RW - 1 - k;
        logic [IW-1:0] w_rem;
        logic [RW-1:0] w_root;
        logic [IW-1:0] w_trial;
        logic          w_ge;
        logic [IW-1:0] r_rem;
        logic [RW-1:0] r_root;

        if (k == 0) begin : g_first
            assign w_rem  = i_val;
            assign w_root = '0;
        end else begin : g_next
            assign w_rem  = w_rem_q[k-1];
            assign w_root = w_root_q[k-1];
        end

        // Growth of the square when this root bit is set
        assign w_trial = (IW'(w_root) << (J + 1)) + (IW'(1) << (2 * J));
        assign w_ge    = w_rem >= w_trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= w_ge ? w_rem - w_trial : w_rem;
                r_root <= w_root | (RW'(w_ge) << J);
            end
        end

        assign w_rem_q[k]  = r_rem;
        assign w_root_q[k] = r_root;
    end

    assign o_root = w_root_q[RW-1];

endmodule

`default_nettype wire

FILE: sv/asc_delay.sv
// Delay line that carries valid bits and side data next to an arithmetic unit.
// Uses no package items; instantiated by analog_stick_conditioner.
`timescale 1ns / 1ps
`default_nettype none

module asc_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_pipe [DEPTH];

    // Advance the line; reset clears the valid bits it carries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) r_pipe[k] <= '0;
        end else if (i_en) begin
            r_pipe[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) r_pipe[k] <= r_pipe[k-1];
        end
    end

    assign o_q = r_pipe[DEPTH-1];

endmodule

`default_nettype wire

FILE: sv/asc_checker.sv
// Port-level checks for analog_stick_conditioner, attached with bind.
// Depends on nothing but the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module asc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_from_stick,
    input logic [15:0] o_out_x,
    input logic [15:0] o_out_y,
    input logic [1:0]  o_destination
);

    // Input backpressure only comes from a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a stalled result");

    // Reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("stalled result dropped");

    // A stalled result keeps its payload
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> ($stable(o_out_x) && $stable(o_out_y)
            && $stable(o_from_stick) && $stable(o_destination)))
        else $error("stalled result changed");

endmodule

bind analog_stick_conditioner asc_checker u_asc_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .o_in_stall(o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_from_stick(o_from_stick),
    .o_out_x(o_out_x),
    .o_out_y(o_out_y),
    .o_destination(o_destination)
);

`default_nettype wire
